// ===== design/mpwm_pkg.sv =====
// Shared types and constants for the multichannel PWM LED driver.
// No dependencies; imported by every module of the block.
package mpwm_pkg;

  localparam int NUM_CH        = 11;
  localparam int ACT_CH        = 10;
  localparam int LVL_W         = 8;
  localparam int BREATH_STEP_DEF = 5;

  localparam logic [LVL_W-1:0] BREATH_MIN_LVL = 8'd20;
  localparam logic [LVL_W-1:0] BREATH_TOP     = 8'd254;
  localparam logic [LVL_W-1:0] BREATH_BOTTOM  = 8'd2;
  localparam logic [LVL_W-1:0] LVL_FULL       = 8'd255;

  localparam int CFG_AW = 4;

  typedef enum logic [1:0] {
    REG_ORB0  = 2'd0,
    REG_ORB1  = 2'd1,
    REG_USER  = 2'd2,
    REG_MODE  = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    ACT_BREATH = 2'd0,
    ACT_ON     = 2'd1,
    ACT_HOLD   = 2'd2
  } act_mode_t;

  typedef logic [LVL_W-1:0] lvl_t;

  // Breathing / activity state as it leaves the update logic
  typedef struct packed {
    lvl_t breath;
    logic falling;
    lvl_t level;
  } act_upd_t;

endpackage

// ===== design/mpwm_breath.sv =====
// Activity level and breathing triangle update taken at a period start.
// Depends on mpwm_pkg.
module mpwm_breath import mpwm_pkg::*; #(
  parameter int BREATH_STEP = BREATH_STEP_DEF
) (
  input  lvl_t        breath,
  input  logic        falling,
  input  lvl_t        level,
  input  logic [1:0]  mode,
  output act_upd_t    upd
);

  localparam lvl_t STEP = lvl_t'(BREATH_STEP);

  lvl_t stepped;

  always_comb begin
    stepped = falling ? (breath - STEP) : (breath + STEP);
    upd.breath  = breath;
    upd.falling = falling;
    upd.level   = level;
    case (mode)
      ACT_BREATH: begin
        upd.level  = (breath > BREATH_MIN_LVL) ? breath : '0;
        upd.breath = stepped;
        if (stepped >= BREATH_TOP) begin
          upd.falling = 1'b1;
        end else if (stepped <= BREATH_BOTTOM) begin
          upd.falling = 1'b0;
        end
      end
      ACT_ON: begin
        upd.level = LVL_FULL;
      end
      default: begin
        // hold, unused code too
        upd.level = level;
      end
    endcase
  end

endmodule

// ===== design/mpwm_cmp.sv =====
// Eleven parallel level-against-position compares giving the pin states.
// Depends on mpwm_pkg.
module mpwm_cmp import mpwm_pkg::*; (
  input  lvl_t              pos,
  input  lvl_t [NUM_CH-1:0] lvl,
  output logic [NUM_CH-1:0] pins
);

  always_comb begin
    for (int n = 0; n < NUM_CH; n++) begin
      pins[n] = (lvl[n] != '0) && ((lvl[n] == LVL_FULL) || (pos < lvl[n]));
    end
  end

endmodule

// ===== design/multichannel_pwm_with_breathing_led.sv =====
// Top level of the eleven-channel 8-bit PWM LED driver with breathing activity LED.
// Depends on mpwm_pkg, mpwm_breath and mpwm_cmp.
//
// Usage:
//   in_*   : one word per timer tick, in_tdata[0] = tick. A tick of 1 advances the
//            8-bit period counter; a tick of 0 leaves all state alone and repeats
//            the pins of the last handled position.
//   out_*  : one word per input word. tdata holds the pin states and the latched
//            activity level, tuser flags a word taken at counter position zero.
//   cfg_*  : APB register port. Levels written take effect at the next period start.
// out_tvalid rises in the cycle after input acceptance; one word is taken every
// cycle while in_tready is high. The output register decouples the two sides:
// in_tready drops only while a result waits and out_tready is low, so a stalled
// receiver holds the word and back-pressures the input one word deep.
// Reset (synchronous, rst_n low) clears registers, counter, latched levels and
// breath state, so all pins are off until levels are written and a period begins.
module multichannel_pwm_with_breathing_led import mpwm_pkg::*; #(
  parameter int BREATH_STEP = BREATH_STEP_DEF
) (
  input  logic              clk,
  input  logic              rst_n,

  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [7:0]        in_tdata,    // [0] tick, [7:1] zero

  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [23:0]       out_tdata,   // [10:0] led_pins, [18:11] activity_level, [23:19] zero
  output logic              out_tuser,   // [0] period_start

  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);

  logic [23:0] orb0_r, orb1_r;
  logic [31:0] user_r;
  logic [1:0]  mode_r;

  lvl_t              cnt_r, cnt_nxt;
  lvl_t [NUM_CH-1:0] lvl_r, lvl_nxt;
  lvl_t              breath_r;
  logic              falling_r;

  logic        out_valid_r;
  logic [23:0] out_data_r, out_data_nxt;
  logic        out_start_r;

  logic        cfg_wr;
  reg_idx_t    cfg_idx;
  logic        in_acc;
  logic        tick;
  logic        start;
  lvl_t        pos;
  act_upd_t    upd;
  logic [NUM_CH-1:0] pins;

  // configuration
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      orb0_r <= '0;
      orb1_r <= '0;
      user_r <= '0;
      mode_r <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_ORB0: orb0_r <= cfg_pwdata[23:0];
        REG_ORB1: orb1_r <= cfg_pwdata[23:0];
        REG_USER: user_r <= cfg_pwdata;
        REG_MODE: mode_r <= cfg_pwdata[1:0];
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_ORB0: cfg_prdata = {8'd0, orb0_r};
      REG_ORB1: cfg_prdata = {8'd0, orb1_r};
      REG_USER: cfg_prdata = user_r;
      REG_MODE: cfg_prdata = {30'd0, mode_r};
    endcase
  end

  // tick handling
  assign in_tready = !out_valid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;
  assign tick      = in_tdata[0];
  assign start     = tick && (cnt_r == '0);
  assign pos       = tick ? cnt_r : (cnt_r - 8'd1);

  mpwm_breath #(.BREATH_STEP(BREATH_STEP)) u_breath (
    .breath  (breath_r),
    .falling (falling_r),
    .level   (lvl_r[ACT_CH]),
    .mode    (mode_r),
    .upd     (upd)
  );

  always_comb begin
    lvl_nxt = lvl_r;
    if (start) begin
      for (int n = 0; n < 3; n++) begin
        lvl_nxt[n]     = orb0_r[8*n +: 8];
        lvl_nxt[3 + n] = orb1_r[8*n +: 8];
      end
      for (int n = 0; n < 4; n++) begin
        lvl_nxt[6 + n] = user_r[8*n +: 8];
      end
      lvl_nxt[ACT_CH] = upd.level;
    end
    cnt_nxt = tick ? (cnt_r + 8'd1) : cnt_r;
  end

  mpwm_cmp u_cmp (
    .pos  (pos),
    .lvl  (lvl_nxt),
    .pins (pins)
  );

  assign out_data_nxt = {5'd0, lvl_nxt[ACT_CH], pins};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r     <= '0;
      lvl_r     <= '0;
      breath_r  <= '0;
      falling_r <= 1'b0;
    end else if (in_acc) begin
      cnt_r <= cnt_nxt;
      lvl_r <= lvl_nxt;
      if (start) begin
        breath_r  <= upd.breath;
        falling_r <= upd.falling;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_data_r  <= out_data_nxt;
      out_start_r <= start;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_start_r;

  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && in_acc && tick |=> cnt_r == $past(cnt_r) + 8'd1)
    else $error("period counter did not advance on a tick");

  a_cnt_hold: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && in_acc && !tick |=> $stable(cnt_r) && $stable(lvl_r))
    else $error("state moved on an idle tick");

  a_lvl_latch: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && !(in_acc && start) |=> $stable(lvl_r))
    else $error("levels changed outside a period start");

  a_start_flag: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && in_acc && start |=> out_tvalid && out_tuser)
    else $error("period start not flagged on the result");

  a_act_on: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && in_acc && start && mode_r == ACT_ON |=> lvl_r[ACT_CH] == LVL_FULL)
    else $error("activity level not full in fully-on mode");

endmodule
